### rtl/avsg_pkg.sv
// Shared types and constants for the A/V PTS sync gate.
// Used by avsg_ctrl, avsg_dp and ts_av_pts_sync_gate.
`timescale 1ns / 1ps
`default_nettype none

package avsg_pkg;

  localparam int POOL_DEPTH_DEF = 16;

  localparam int PID_W   = 13;
  localparam int TAG_W   = 16;
  localparam int REG_W   = 16;
  localparam int PTS_W   = 33;
  localparam int CALC_W  = 36;
  localparam int CIDX_W  = 8;

  localparam logic [REG_W-1:0]  PID_NONE    = 16'hFFFF;
  localparam logic [CALC_W-1:0] PTS_WRAP    = 36'h200000000;
  localparam logic [CALC_W-1:0] JUMP_LIMIT  = 36'd450000;
  localparam logic [CALC_W-1:0] LATE_LIMIT  = 36'd90000;
  localparam logic [CALC_W-1:0] EARLY_LIMIT = 36'd18000;

  localparam logic [CIDX_W-1:0] REG_VIDEO_PID  = 8'd0;
  localparam logic [CIDX_W-1:0] REG_AUDIO_PID  = 8'd1;
  localparam logic [CIDX_W-1:0] REG_MAPPED_PID = 8'd2;
  localparam logic [CIDX_W-1:0] REG_SYNC_EN    = 8'd3;
  localparam logic [CIDX_W-1:0] REG_ONE_SEG    = 8'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH,
    ST_CUR,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic pop_emit;
    logic cur_emit;
    logic hold_wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic pass;
    logic flush;
    logic hold;
    logic empty;
    logic full;
    logic rd_ok;
    logic release_ok;
    logic can_emit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/avsg_ctrl.sv
// Sequencer for the A/V PTS sync gate: one packet at a time.
// Depends on avsg_pkg; drives avsg_dp through cmd_t, reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module avsg_ctrl import avsg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.drop) begin
          state_next = ST_FIN;
        end else if (!sts.pass && sts.flush && !sts.empty) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_CUR;
        end
      end
      ST_FLUSH: begin
        if (sts.empty) begin
          state_next = ST_CUR;
        end else if (sts.rd_ok && sts.can_emit) begin
          cmd.pop_emit = 1'b1;
        end
      end
      ST_CUR: begin
        if (sts.hold) begin
          if (sts.full) begin
            // oldest word leaves before the new one goes in
            if (sts.rd_ok && sts.can_emit) begin
              cmd.pop_emit = 1'b1;
            end
          end else begin
            cmd.hold_wr = 1'b1;
            state_next  = ST_DRAIN;
          end
        end else if (sts.can_emit) begin
          cmd.cur_emit = 1'b1;
          state_next   = sts.pass ? ST_FIN : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.empty) begin
          state_next = ST_FIN;
        end else if (sts.rd_ok) begin
          if (!sts.release_ok) begin
            state_next = ST_FIN;
          end else if (sts.can_emit) begin
            cmd.pop_emit = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/avsg_dp.sv
// Datapath of the A/V PTS sync gate: registers, stamps, hold pool, output word.
// Depends on avsg_pkg; commanded by avsg_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module avsg_dp import avsg_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  wire logic [TAG_W-1:0]   packet_tag,
  input  wire logic [PID_W-1:0]   pid,
  input  wire logic               unit_start,
  input  wire logic [7:0]         payload_size,
  input  wire logic [63:0]        payload_head_low,
  input  wire logic [47:0]        payload_head_high,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [TAG_W-1:0]        out_packet_tag,
  output logic [PID_W-1:0]        out_pid,
  output logic                    last_of_run,
  input  wire logic               cfg_valid,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]   cfg_data
);

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int ENT_W = TAG_W + PID_W + PTS_W;

  // configuration
  logic [REG_W-1:0] video_pid, audio_pid, mapped_pid;
  logic             sync_en, one_seg;

  // stamps: value plus valid (invalid = no stamp)
  logic [PTS_W-1:0] vs, vs_prior, as_, as_prior;
  logic             vs_v, vsp_v, as_v, asp_v;

  // current item
  logic [TAG_W-1:0] cur_tag;
  logic [PID_W-1:0] cur_pid;
  logic             cur_video, drop, pass;
  logic             hold;
  logic [PTS_W-1:0] hold_pts;
  logic [CALC_W-1:0] ref_val;
  logic             ref_v;

  // pool
  logic [ENT_W-1:0] mem [POOL_DEPTH];
  logic [ENT_W-1:0] rd;
  logic             rd_ok;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;

  // pending and output words
  logic             pend_valid;
  logic [TAG_W-1:0] pend_tag;
  logic [PID_W-1:0] pend_pid;

  // ---------------------------------------------------------------- load
  logic             is_av, is_video_c, pts_ok;
  logic [PTS_W-1:0] pts_c;
  logic [PID_W-1:0] opid_c;

  always_comb begin
    is_video_c = ({3'b0, pid} == video_pid);
    is_av      = is_video_c || ({3'b0, pid} == audio_pid);
    opid_c     = pid;
    if (is_av && !is_video_c && mapped_pid != PID_NONE) begin
      opid_c = mapped_pid[PID_W-1:0];
    end
    pts_ok = (payload_size >= 8'd14) && (payload_head_low[63:40] == 24'h000001)
             && payload_head_low[7];
    pts_c  = {payload_head_high[35:33], payload_head_high[31:24],
              payload_head_high[23:17], payload_head_high[15:8],
              payload_head_high[7:1]};
  end

  // ---------------------------------------------------------------- eval
  logic [PTS_W-1:0]  s_sel, p_sel;
  logic              s_v, p_v;
  logic [CALC_W-1:0] s36, p36, adj, ref_c;
  logic              ge_jump, flush_c, hold_c;

  always_comb begin
    s_sel = one_seg ? as_ : vs;
    p_sel = one_seg ? as_prior : vs_prior;
    s_v   = one_seg ? as_v : vs_v;
    p_v   = one_seg ? asp_v : vsp_v;
    s36   = CALC_W'(s_sel);
    p36   = CALC_W'(p_sel);
    adj   = (s36 < p36) ? s36 + PTS_WRAP : s36;
    ge_jump = (s36 >= p36) ? ((s36 - p36) >= JUMP_LIMIT) : ((p36 - s36) >= JUMP_LIMIT);
    if (one_seg) begin
      flush_c = p_v && (adj >= p36 + JUMP_LIMIT);
      ref_c   = p_v ? adj : s36;
    end else begin
      flush_c = p_v && ge_jump && (adj >= p36 + JUMP_LIMIT);
      ref_c   = (p_v && ge_jump) ? adj : s36;
    end
    hold_c = !flush_c && (one_seg ? (cur_video && vs_v) : (!cur_video && as_v));
  end

  // ---------------------------------------------------------------- release test
  logic [CALC_W-1:0] p_head;
  logic              rel_c;

  always_comb begin
    p_head = CALC_W'(rd[PTS_W-1:0]);
    if (one_seg) begin
      rel_c = !ref_v || (p_head <= ref_val + LATE_LIMIT) || (p_head >= ref_val + JUMP_LIMIT);
    end else begin
      rel_c = !ref_v || (p_head + EARLY_LIMIT <= ref_val)
              || (p_head >= ref_val + JUMP_LIMIT);
    end
  end

  // ---------------------------------------------------------------- pool indexes
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail, head_inc;
  logic             out_free, mode_clr;

  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(POOL_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(POOL_DEPTH);
    end
    tail     = tail_sum[IDX_W-1:0];
    head_inc = (head == IDX_W'(POOL_DEPTH - 1)) ? '0 : head + 1'b1;
    out_free = !out_valid || !out_stall;
    mode_clr = cfg_valid && (((cfg_index == REG_SYNC_EN) && (cfg_data[0] != sync_en))
               || ((cfg_index == REG_ONE_SEG) && (cfg_data[0] != one_seg)));
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_wr) begin
      mem[tail] <= {cur_tag, cur_pid, hold_pts};
    end
    rd <= mem[head];
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      video_pid  <= PID_NONE;
      audio_pid  <= PID_NONE;
      mapped_pid <= PID_NONE;
      sync_en    <= 1'b0;
      one_seg    <= 1'b0;
      vs_v       <= 1'b0;
      vsp_v      <= 1'b0;
      as_v       <= 1'b0;
      asp_v      <= 1'b0;
      head       <= '0;
      count      <= '0;
      rd_ok      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_ok <= !(cmd.pop_emit || cmd.hold_wr);
      if (cfg_valid) begin
        case (cfg_index)
          REG_VIDEO_PID:  video_pid  <= cfg_data;
          REG_AUDIO_PID:  audio_pid  <= cfg_data;
          REG_MAPPED_PID: mapped_pid <= cfg_data;
          REG_SYNC_EN:    sync_en    <= cfg_data[0];
          REG_ONE_SEG:    one_seg    <= cfg_data[0];
          default: ;
        endcase
      end
      if (mode_clr) begin
        vs_v  <= 1'b0;
        vsp_v <= 1'b0;
        as_v  <= 1'b0;
        asp_v <= 1'b0;
        count <= '0;
      end
      if (cmd.load && is_av && unit_start && pts_ok) begin
        if (is_video_c) begin
          vsp_v <= vs_v;
          vs_v  <= 1'b1;
        end else begin
          asp_v <= as_v;
          as_v  <= 1'b1;
        end
      end
      if (cmd.eval && !pass && flush_c) begin
        vs_v  <= 1'b0;
        vsp_v <= 1'b0;
        as_v  <= 1'b0;
        asp_v <= 1'b0;
      end
      if (cmd.pop_emit) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end else if (cmd.hold_wr) begin
        count <= count + 1'b1;
      end
      // output word register
      if (cmd.fin || ((cmd.pop_emit || cmd.cur_emit) && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.pop_emit || cmd.cur_emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.fin) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_tag   <= packet_tag;
      cur_pid   <= opid_c;
      cur_video <= is_video_c;
      drop      <= !is_av && ({3'b0, pid} == mapped_pid);
      pass      <= !is_av || !sync_en;
      if (is_av && unit_start && pts_ok) begin
        if (is_video_c) begin
          vs_prior <= vs;
          vs       <= pts_c;
        end else begin
          as_prior <= as_;
          as_      <= pts_c;
        end
      end
    end
    if (cmd.eval) begin
      hold     <= !pass && hold_c;
      hold_pts <= one_seg ? vs : as_;
      ref_val  <= ref_c;
      ref_v    <= s_v && !flush_c;
    end
    if (cmd.pop_emit || cmd.cur_emit) begin
      if (pend_valid) begin
        out_packet_tag <= pend_tag;
        out_pid        <= pend_pid;
        last_of_run    <= 1'b0;
      end
      pend_tag <= cmd.pop_emit ? rd[ENT_W-1 -: TAG_W] : cur_tag;
      pend_pid <= cmd.pop_emit ? rd[PTS_W +: PID_W] : cur_pid;
    end else if (cmd.fin) begin
      out_packet_tag <= pend_tag;
      out_pid        <= pend_pid;
      last_of_run    <= 1'b1;
    end
  end

  always_comb begin
    sts.drop       = drop;
    sts.pass       = pass;
    sts.flush      = flush_c;
    sts.hold       = hold;
    sts.empty      = (count == '0);
    sts.full       = (count == CNT_W'(POOL_DEPTH));
    sts.rd_ok      = rd_ok;
    sts.release_ok = rel_c;
    sts.can_emit   = !pend_valid || out_free;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

endmodule

`default_nettype wire

### rtl/ts_av_pts_sync_gate.sv
// Transport-stream PID filter, audio PID remap and A/V PTS alignment gate.
// Usage:
//  - Input channel (in_valid/in_stall) takes one packet descriptor per word.
//  - Output channel (out_valid/out_stall) gives released packets; last_of_run
//    marks the final word caused by one input. A dropped input gives none.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//    ready; write only while idle. Index 0 video PID, 1 audio PID, 2 mapped
//    audio PID, 3 sync enable, 4 one-seg mode. A changed mode bit empties
//    the pool and clears all stamps.
//  - One input at a time. With sync on, an A/V packet adds a drain check of the
//    pool after its own word is emitted or held. Words popped from the pool
//    pass through a registered pool read, and a full pool pops its oldest
//    word to make room for a hold. Output stalls hold up the sequencer.
//  - Each word waits in a pending register and moves to the output register
//    when a further word is emitted or when the sequencer finishes the input.
//  - A stall on the output holds the output word; the sequencer waits and
//    in_stall stays high until the last word of the input is in the output reg.
//  - Synchronous reset empties the pool, clears stamps, loads register
//    defaults (PIDs 65535, sync off, normal mode).
// Depends on avsg_pkg, avsg_ctrl, avsg_dp.
`timescale 1ns / 1ps
`default_nettype none

module ts_av_pts_sync_gate import avsg_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [TAG_W-1:0]   packet_tag,
  input  wire logic [PID_W-1:0]   pid,
  input  wire logic               unit_start,
  input  wire logic [7:0]         payload_size,
  input  wire logic [63:0]        payload_head_low,
  input  wire logic [47:0]        payload_head_high,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [TAG_W-1:0]        out_packet_tag,
  output logic [PID_W-1:0]        out_pid,
  output logic                    last_of_run,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  avsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  avsg_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .packet_tag        (packet_tag),
    .pid               (pid),
    .unit_start        (unit_start),
    .payload_size      (payload_size),
    .payload_head_low  (payload_head_low),
    .payload_head_high (payload_head_high),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_tag    (out_packet_tag),
    .out_pid           (out_pid),
    .last_of_run       (last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

endmodule

`default_nettype wire

### sim/tb_ts_av_pts_sync_gate.sv
// Self-checking testbench for ts_av_pts_sync_gate: PID filter, audio remap, PTS gate.
// Uses avsg_pkg for widths and register indexes; predicts release order in-bench.
`timescale 1ns / 1ps

module tb_ts_av_pts_sync_gate;
  import avsg_pkg::*;

  localparam int POOL_N = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT = 60;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 8'd7;
  localparam longint WRAP33 = 64'h200000000;
  localparam longint JUMP = 450000;
  localparam longint LATE = 90000;
  localparam longint EARLY = 18000;

  typedef struct {
    logic [TAG_W-1:0] tag;
    logic [PID_W-1:0] pid;
    logic             last;
  } word_t;

  typedef struct {
    logic [TAG_W-1:0] tag;
    logic [PID_W-1:0] pid;
    logic             us;
    logic [7:0]       size;
    logic [63:0]      lo;
    logic [47:0]      hi;
    bit               typed;  // expected word read off directly: passes unchanged
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [TAG_W-1:0] packet_tag;
  logic [PID_W-1:0] pid;
  logic unit_start;
  logic [7:0] payload_size;
  logic [63:0] payload_head_low;
  logic [47:0] payload_head_high;
  logic out_valid, out_stall;
  logic [TAG_W-1:0] out_packet_tag;
  logic [PID_W-1:0] out_pid;
  logic last_of_run;
  logic cfg_valid, cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  ts_av_pts_sync_gate dut (.*);

  // predictor state
  logic [15:0] m_vpid, m_apid, m_mpid;
  logic m_sync, m_oneseg;
  longint v_st, v_prior, a_st, a_prior;
  logic [TAG_W-1:0] pl_tag[POOL_N];
  logic [PID_W-1:0] pl_pid[POOL_N];
  longint pl_pts[POOL_N];
  int pl_head, pl_count;

  word_t release_q[$];   // words expected from the DUT, oldest first
  word_t run_q[$];       // words of the packet being predicted
  bit typed_row;
  word_t typed_word;

  int errors, words_seen, pkts_sent, jumps_made;
  int cycles;
  bit quiet;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, release_q.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic void clear_stamps();
    v_st = -1; v_prior = -1; a_st = -1; a_prior = -1;
    pl_head = 0; pl_count = 0;
  endfunction

  function automatic void emit_word(logic [TAG_W-1:0] t, logic [PID_W-1:0] p);
    word_t w;
    w.tag = t; w.pid = p; w.last = 0;
    run_q.push_back(w);
  endfunction

  function automatic void pop_pool();
    emit_word(pl_tag[pl_head], pl_pid[pl_head]);
    pl_head = (pl_head + 1) % POOL_N;
    pl_count--;
  endfunction

  function automatic void hold_pkt(logic [TAG_W-1:0] t, logic [PID_W-1:0] p, longint s);
    int slot;
    if (pl_count >= POOL_N) pop_pool();
    slot = (pl_head + pl_count) % POOL_N;
    pl_tag[slot] = t; pl_pid[slot] = p; pl_pts[slot] = s;
    pl_count++;
  endfunction

  function automatic logic [7:0] hbyte(logic [63:0] lo, logic [47:0] hi, int i);
    if (i < 8) return lo[63-8*i -: 8];
    return hi[47-8*(i-8) -: 8];
  endfunction

  function automatic longint pes_stamp(logic [7:0] sz, logic [63:0] lo, logic [47:0] hi);
    logic [32:0] s;
    logic [7:0] b7, b9, b11, b13;
    if (sz < 14) return -1;
    if (hbyte(lo, hi, 0) != 0 || hbyte(lo, hi, 1) != 0 || hbyte(lo, hi, 2) != 1) return -1;
    b7 = hbyte(lo, hi, 7);
    b9 = hbyte(lo, hi, 9);
    b11 = hbyte(lo, hi, 11);
    b13 = hbyte(lo, hi, 13);
    if (!b7[7]) return -1;
    s = {b9[3:1], hbyte(lo, hi, 10), b11[7:1], hbyte(lo, hi, 12), b13[7:1]};
    return longint'(s);
  endfunction

  function automatic void write_reg(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] d);
    case (idx)
      REG_VIDEO_PID:  m_vpid = d;
      REG_AUDIO_PID:  m_apid = d;
      REG_MAPPED_PID: m_mpid = d;
      REG_SYNC_EN:    if (d[0] != m_sync) begin clear_stamps(); m_sync = d[0]; end
      REG_ONE_SEG:    if (d[0] != m_oneseg) begin clear_stamps(); m_oneseg = d[0]; end
      default: ;
    endcase
  endfunction

  // Computes the released words for one accepted packet into run_q.
  function automatic void gate_packet(logic [TAG_W-1:0] t, logic [PID_W-1:0] p, logic us,
                                      logic [7:0] sz, logic [63:0] lo, logic [47:0] hi);
    logic [15:0] p16;
    logic [PID_W-1:0] opid;
    bit is_vid;
    longint s, ref_st, d, head_pts;
    p16 = {3'b0, p};
    opid = p;
    run_q.delete();
    if (p16 != m_vpid && p16 != m_apid) begin
      if (p16 != m_mpid) emit_word(t, p);
      return;
    end
    is_vid = (p16 == m_vpid);
    if (!is_vid && m_mpid != PID_NONE) opid = m_mpid[PID_W-1:0];
    if (us) begin
      s = pes_stamp(sz, lo, hi);
      if (s >= 0) begin
        if (is_vid) begin v_prior = v_st; v_st = s; end
        else begin a_prior = a_st; a_st = s; end
      end
    end
    if (!m_sync) begin
      emit_word(t, opid);
      return;
    end
    if (m_oneseg) begin
      ref_st = a_st;
      if (a_prior >= 0) begin
        if (ref_st < a_prior) ref_st += WRAP33;
        if (ref_st >= a_prior + JUMP) begin
          while (pl_count > 0) pop_pool();
          clear_stamps();
          ref_st = -1;
        end
      end
      if (is_vid && v_st >= 0) hold_pkt(t, opid, v_st);
      else emit_word(t, opid);
      while (pl_count > 0) begin
        head_pts = pl_pts[pl_head];
        if (ref_st < 0 || head_pts <= ref_st + LATE || head_pts >= ref_st + JUMP) pop_pool();
        else break;
      end
    end else begin
      ref_st = v_st;
      if (v_prior >= 0) begin
        d = ref_st - v_prior;
        if (d < 0) d = -d;
        if (d >= JUMP) begin
          if (ref_st < v_prior) ref_st += WRAP33;
          if (ref_st >= v_prior + JUMP) begin
            while (pl_count > 0) pop_pool();
            clear_stamps();
            ref_st = -1;
          end
        end
      end
      if (!is_vid && a_st >= 0) hold_pkt(t, opid, a_st);
      else emit_word(t, opid);
      while (pl_count > 0) begin
        head_pts = pl_pts[pl_head];
        if (ref_st < 0 || head_pts + EARLY <= ref_st || head_pts >= ref_st + JUMP) pop_pool();
        else break;
      end
    end
  endfunction

  // input and config monitors
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      gate_packet(packet_tag, pid, unit_start, payload_size, payload_head_low,
                  payload_head_high);
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1;
      if (typed_row) begin
        release_q.push_back(typed_word);
      end else begin
        foreach (run_q[i]) release_q.push_back(run_q[i]);
      end
    end
    if (!rst && cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
  end

  // output checker
  always @(posedge clk) begin
    word_t e;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (release_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual tag %h pid %h last %b",
                 $time, out_packet_tag, out_pid, last_of_run);
        errors++;
      end else begin
        e = release_q.pop_front();
        if (e.tag !== out_packet_tag) begin
          $display("%0t tag mismatch: expected %h actual %h", $time, e.tag, out_packet_tag);
          errors++;
        end
        if (e.pid !== out_pid) begin
          $display("%0t pid mismatch: expected %h actual %h", $time, e.pid, out_pid);
          errors++;
        end
        if (e.last !== last_of_run) begin
          $display("%0t last_of_run mismatch: expected %b actual %b", $time, e.last,
                   last_of_run);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_stall = 0;
    forever begin
      n = $urandom_range(1, 8);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send(row_t r);
    int gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    packet_tag <= r.tag;
    pid <= r.pid;
    unit_start <= r.us;
    payload_size <= r.size;
    payload_head_low <= r.lo;
    payload_head_high <= r.hi;
    typed_row <= r.typed;
    typed_word <= '{tag: r.tag, pid: r.pid, last: 1'b1};
    do @(posedge clk); while (in_stall);
    pkts_sent++;
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (release_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic setup(logic [15:0] v, logic [15:0] a, logic [15:0] m, logic s, logic o);
    settle();
    cfg_write(REG_VIDEO_PID, v);
    cfg_write(REG_AUDIO_PID, a);
    cfg_write(REG_MAPPED_PID, m);
    cfg_write(REG_SYNC_EN, {15'd0, s});
    cfg_write(REG_ONE_SEG, {15'd0, o});
    @(posedge clk);
  endtask

  // PES header with a 33-bit PTS in bytes 9..13
  function automatic row_t pes_row(logic [TAG_W-1:0] t, logic [PID_W-1:0] p, longint s);
    row_t r;
    logic [32:0] q;
    q = s[32:0];
    r.tag = t; r.pid = p; r.us = 1; r.typed = 0;
    r.size = 8'($urandom_range(14, 184));
    r.lo = {24'h000001, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom) | 8'h80};
    r.hi = {8'($urandom), 4'b0010, q[32:30], 1'b1, q[29:22], q[21:15], 1'b1, q[14:7],
            q[6:0], 1'b1};
    return r;
  endfunction

  longint vclk, aclk;

  task automatic random_phase(int count, logic [PID_W-1:0] vp, logic [PID_W-1:0] ap,
                              logic [PID_W-1:0] mp);
    row_t r;
    int sel;
    for (int k = 0; k < count; k++) begin
      vclk = (vclk + $urandom_range(0, 6000)) % WRAP33;
      aclk = (aclk + $urandom_range(0, 6000)) % WRAP33;
      if ($urandom_range(0, 40) == 0) begin
        vclk = (vclk + $urandom_range(450000, 2000000)) % WRAP33;
        jumps_made++;
      end
      if ($urandom_range(0, 40) == 0) begin
        aclk = (vclk + $urandom_range(0, 900000)) % WRAP33;
        jumps_made++;
      end
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        r = pes_row(16'($urandom), vp, vclk);
        if ($urandom_range(0, 2) != 0) begin
          r.us = 0;
        end
      end else if (sel < 75) begin
        r = pes_row(16'($urandom), ap, aclk);
        if ($urandom_range(0, 2) != 0) r.us = 0;
      end else begin
        r.tag = 16'($urandom);
        r.pid = (sel < 85) ? mp : 13'($urandom);
        r.us = 1'($urandom);
        r.size = 8'($urandom_range(0, 184));
        r.lo = {$urandom, $urandom};
        r.hi = {16'($urandom), $urandom};
        r.typed = 0;
        if (sel < 90) r.pid = ($urandom_range(0, 1) == 0) ? vp : ap;
      end
      send(r);
    end
  endtask

  row_t dir_rows[] = '{
    '{16'h0000, 13'h0000, 1'b0, 8'd0,   64'h0, 48'h0, 1'b1},
    '{16'hFFFF, 13'h1FFF, 1'b1, 8'd184, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1},
    '{16'h1234, 13'h0100, 1'b1, 8'd14,  64'h0000_01E0_0000_8080, 48'h0521_0001_0001, 1'b1},
    '{16'h5555, 13'h0AAA, 1'b0, 8'd128, 64'hAAAA_5555_AAAA_5555, 48'h5555_AAAA_5555, 1'b1},
    '{16'hAAAA, 13'h1555, 1'b1, 8'd13,  64'h0000_01E0_0000_8080, 48'h0521_0001_0001, 1'b1},
    '{16'h8000, 13'h1000, 1'b1, 8'd184, 64'h0000_0200_0000_8080, 48'h0521_0001_0001, 1'b1},
    '{16'h0001, 13'h0001, 1'b1, 8'd100, 64'h0000_01E0_0000_8000, 48'hFFFF_FFFF_FFFF, 1'b1}
  };

  initial begin
    rst = 1;
    in_valid = 0; packet_tag = 0; pid = 0; unit_start = 0; payload_size = 0;
    payload_head_low = 0; payload_head_high = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    typed_row = 0; typed_word = '{tag: '0, pid: '0, last: 1'b0};
    errors = 0; words_seen = 0; pkts_sent = 0; jumps_made = 0; cycles = 0; quiet = 0;
    m_vpid = PID_NONE; m_apid = PID_NONE; m_mpid = PID_NONE; m_sync = 0; m_oneseg = 0;
    for (int i = 0; i < POOL_N; i++) begin
      pl_tag[i] = 0; pl_pid[i] = 0; pl_pts[i] = 0;
    end
    clear_stamps();
    vclk = 1000; aclk = 3000;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset defaults: nothing matches, every packet passes as is
    foreach (dir_rows[i]) send(dir_rows[i]);
    settle();
    cfg_write(REG_UNUSED, 16'h1234);

    setup(16'd100, 16'd200, PID_NONE, 1'b1, 1'b0);
    random_phase(60, 13'd100, 13'd200, 13'd300);
    setup(16'd100, 16'd200, 16'd300, 1'b1, 1'b0);
    random_phase(45, 13'd100, 13'd200, 13'd300);
    vclk = WRAP33 - 200000; aclk = WRAP33 - 150000;  // cross the 33-bit wrap
    setup(16'd100, 16'd200, 16'd300, 1'b1, 1'b1);
    random_phase(50, 13'd100, 13'd200, 13'd300);
    setup(16'd0, 16'd8191, 16'd9000, 1'b0, 1'b1);     // wide mapped PID gets masked
    random_phase(30, 13'd0, 13'd8191, 13'd808);
    setup(16'd8191, 16'd0, 16'd0, 1'b1, 1'b0);
    random_phase(40, 13'd8191, 13'd0, 13'd0);
    setup(16'd40000, 16'd5, 16'hFFFE, 1'b1, 1'b1);
    quiet = 1;
    random_phase(30, 13'd5, 13'd5, 13'h1FFE);

    settle();
    $display("sent %0d packets across 7 register settings, %0d words checked, %0d stamp jumps",
             pkts_sent, words_seen, jumps_made);
    if (errors == 0 && release_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d words never arrived", errors, release_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
